// ===== rtl/core/gbsel_pkg.sv =====
// ----------------------------------------------------------------------------
// gbsel_pkg
// Shared types and constants of the grid bucketing top-N selector.
// ----------------------------------------------------------------------------
package gbsel_pkg;

  localparam int COORD_W    = 16;
  localparam int CFG_W      = 13;
  localparam int KEEP_CFG_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CELL_IDX_W = 26;

  localparam logic [CFG_W-1:0]      CFG_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0]      CFG_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0]      CFG_SIZE_RST   = 13'd64;
  localparam logic [KEEP_CFG_W-1:0] CFG_KEEP_RST   = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_CELL_SIZE    = 2'd2,
    CFG_KEEP_COUNT   = 2'd3
  } gbsel_cfg_idx_t;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] score;
  } gbsel_point_t;

  typedef struct packed {
    logic                  kind;
    logic [CELL_IDX_W-1:0] cell_idx;
    gbsel_point_t          pt;
  } gbsel_item_t;

  typedef struct packed {
    logic [CFG_W-1:0]      image_width;
    logic [CFG_W-1:0]      image_height;
    logic [CFG_W-1:0]      cell_size;
    logic [KEEP_CFG_W-1:0] keep_count;
  } gbsel_cfg_t;

endpackage

// ===== rtl/core/gbsel_ram.sv =====
// ----------------------------------------------------------------------------
// gbsel_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gbsel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gbsel_fifo.sv =====
// ----------------------------------------------------------------------------
// gbsel_fifo
// Two-entry queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module gbsel_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  gbsel_pkg::gbsel_item_t push_item,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output gbsel_pkg::gbsel_item_t pop_item
);
  import gbsel_pkg::*;

  gbsel_item_t mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/gbsel_front.sv =====
// ----------------------------------------------------------------------------
// gbsel_front
// Accepts transactions and works out the grid cell of each added point
// with a four-lane bit-serial divider and one multiply.
// ----------------------------------------------------------------------------
module gbsel_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [gbsel_pkg::COORD_W-1:0]        in_point_x,
  input  logic [gbsel_pkg::COORD_W-1:0]        in_point_y,
  input  logic [gbsel_pkg::COORD_W-1:0]        in_score,
  input  gbsel_pkg::gbsel_cfg_t                cfg,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output gbsel_pkg::gbsel_item_t               push_item
);
  import gbsel_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_DIV   = 5'b00010,
    F_CLAMP = 5'b00100,
    F_MUL   = 5'b01000,
    F_PUSH  = 5'b10000
  } front_state_t;

  front_state_t     state_r;
  gbsel_item_t      item_r;
  logic [CFG_W-1:0] dvd_r [4];
  logic [CFG_W-1:0] rem_r [4];
  logic [CFG_W-1:0] dvd_nxt [4];
  logic [CFG_W-1:0] rem_nxt [4];
  logic [3:0]       cnt_r;
  logic [CFG_W-1:0] col_r;
  logic [CFG_W-1:0] row_r;
  logic [CFG_W-1:0] rows_r;
  logic [CFG_W-1:0] divisor;
  logic [CFG_W-1:0] cols_c;
  logic [CFG_W-1:0] rows_c;
  logic [CFG_W:0]   trial [4];
  logic [CELL_IDX_W-1:0] prod;

  assign divisor = (cfg.cell_size == '0) ? CFG_W'(1) : cfg.cell_size;

  // One quotient bit per lane and cycle: lanes are width, height, and x and y shifted down four bits.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      trial[l] = {rem_r[l], dvd_r[l][CFG_W-1]};
      if (trial[l] >= {1'b0, divisor}) begin
        rem_nxt[l] = CFG_W'(trial[l] - {1'b0, divisor});
        dvd_nxt[l] = {dvd_r[l][CFG_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = trial[l][CFG_W-1:0];
        dvd_nxt[l] = {dvd_r[l][CFG_W-2:0], 1'b0};
      end
    end
  end

  assign cols_c = (dvd_r[0] == '0) ? CFG_W'(1) : dvd_r[0];
  assign rows_c = (dvd_r[1] == '0) ? CFG_W'(1) : dvd_r[1];
  assign prod   = {13'd0, col_r} * {13'd0, rows_r};

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_item  = item_r;

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        item_r.kind     <= in_kind;
        item_r.cell_idx <= '0;
        item_r.pt.x     <= in_point_x;
        item_r.pt.y     <= in_point_y;
        item_r.pt.score <= in_score;
        dvd_r[0] <= cfg.image_width;
        dvd_r[1] <= cfg.image_height;
        dvd_r[2] <= {1'b0, in_point_x[COORD_W-1:4]};
        dvd_r[3] <= {1'b0, in_point_y[COORD_W-1:4]};
        for (int l = 0; l < 4; l++) begin
          rem_r[l] <= '0;
        end
      end
      F_DIV: begin
        for (int l = 0; l < 4; l++) begin
          dvd_r[l] <= dvd_nxt[l];
          rem_r[l] <= rem_nxt[l];
        end
      end
      F_CLAMP: begin
        col_r  <= (dvd_r[2] > cols_c - CFG_W'(1)) ? cols_c - CFG_W'(1) : dvd_r[2];
        row_r  <= (dvd_r[3] > rows_c - CFG_W'(1)) ? rows_c - CFG_W'(1) : dvd_r[3];
        rows_r <= rows_c;
      end
      F_MUL: begin
        item_r.cell_idx <= prod + CELL_IDX_W'(row_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            cnt_r   <= 4'd13;
            state_r <= (in_kind == KIND_ADD) ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          cnt_r <= cnt_r - 4'd1;
          if (cnt_r == 4'd1) begin
            state_r <= F_CLAMP;
          end
        end
        F_CLAMP: state_r <= F_MUL;
        F_MUL:   state_r <= F_PUSH;
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/gbsel_back.sv =====
// ----------------------------------------------------------------------------
// gbsel_back
// Carries out queued transactions: sorted insertion into a cell, and the
// fetch scan over the cells, with the result register.
// ----------------------------------------------------------------------------
module gbsel_back #(
  parameter int MAX_CELLS = 256,
  parameter int MAX_KEEP  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  gbsel_pkg::gbsel_item_t            q_item,
  input  logic [gbsel_pkg::KEEP_CFG_W-1:0]  keep_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gbsel_pkg::COORD_W-1:0]     out_x,
  output logic [gbsel_pkg::COORD_W-1:0]     out_y,
  output logic [gbsel_pkg::COORD_W-1:0]     out_score,
  output logic                              out_is_last,
  output logic                              out_is_empty
);
  import gbsel_pkg::*;

  localparam int CW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int KW  = $clog2(MAX_KEEP + 1);
  localparam int SCW = $clog2(MAX_CELLS + 1);
  localparam int PW  = $bits(gbsel_point_t);

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_AHELD = 9'b000000010,
    B_ARD   = 9'b000000100,
    B_ACMP  = 9'b000001000,
    B_AWR   = 9'b000010000,
    B_FRD   = 9'b000100000,
    B_FCHK  = 9'b001000000,
    B_FDAT  = 9'b010000000,
    B_EMIT  = 9'b100000000
  } back_state_t;

  back_state_t      state_r;
  logic [CW-1:0]    cur_cell_r;
  gbsel_point_t     cur_pt_r;
  logic [KW-1:0]    n_r;
  logic [KW-1:0]    i_r;
  logic [KW-1:0]    pos_r;
  logic [SCW-1:0]   sc_r;
  logic [KW-1:0]    ss_r;
  logic             phase_r;
  logic [CW-1:0]    fetch_cell_r;
  logic [KW-1:0]    fetch_slot_r;
  logic [MAX_CELLS-1:0] nz_r;
  gbsel_point_t     res_pt_r;
  logic             res_last_r;
  logic             res_empty_r;
  gbsel_point_t     out_pt_r;
  logic             out_last_r;
  logic             out_empty_r;
  logic             out_valid_r;

  logic [KW-1:0]    k_eff;
  logic [CW-1:0]    hold_cell;
  logic [KW-1:0]    fill_rd;
  logic [KW-1:0]    held;
  logic [KW-1:0]    fill_new;
  logic             fill_we;
  logic [CW-1:0]    fill_raddr;
  logic             st_we;
  logic [CW+SW-1:0] st_waddr;
  logic [PW-1:0]    st_wdata;
  logic [CW+SW-1:0] st_raddr;
  gbsel_point_t     st_rd;
  logic             emit_go;

  assign k_eff = (int'(keep_count) > MAX_KEEP) ? KW'(MAX_KEEP) : KW'(keep_count);

  // Points held in a cell: zero unless written this frame, never above keep.
  assign hold_cell = (state_r == B_FCHK) ? sc_r[CW-1:0] : cur_cell_r;
  assign held      = !nz_r[hold_cell] ? '0 : ((fill_rd < k_eff) ? fill_rd : k_eff);
  assign fill_new  = (pos_r >= k_eff || n_r == k_eff) ? n_r : n_r + KW'(1);

  always_comb begin
    case (state_r)
      B_IDLE:  fill_raddr = q_item.cell_idx[CW-1:0];
      B_FRD:   fill_raddr = sc_r[CW-1:0];
      default: fill_raddr = cur_cell_r;
    endcase
  end

  assign fill_we = (state_r == B_AWR);

  always_comb begin
    st_we    = 1'b0;
    st_waddr = {cur_cell_r, SW'(pos_r)};
    st_wdata = cur_pt_r;
    if (state_r == B_ACMP) begin
      st_we    = (st_rd.score < cur_pt_r.score) && (i_r < k_eff);
      st_waddr = {cur_cell_r, SW'(i_r)};
      st_wdata = st_rd;
    end else if (state_r == B_AWR) begin
      st_we    = (pos_r < k_eff);
    end
    if (state_r == B_FCHK) begin
      st_raddr = {sc_r[CW-1:0], SW'(ss_r)};
    end else begin
      st_raddr = {cur_cell_r, SW'(i_r - KW'(1))};
    end
  end

  gbsel_ram #(.WIDTH(KW), .DEPTH(2**CW)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (cur_cell_r),
    .wdata (fill_new),
    .raddr (fill_raddr),
    .rdata (fill_rd)
  );

  gbsel_ram #(.WIDTH(PW), .DEPTH(2**(CW+SW))) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rd)
  );

  assign q_ready      = (state_r == B_IDLE);
  assign emit_go      = (state_r == B_EMIT) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign out_x        = out_pt_r.x;
  assign out_y        = out_pt_r.y;
  assign out_score    = out_pt_r.score;
  assign out_is_last  = out_last_r;
  assign out_is_empty = out_empty_r;

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_pt_r    <= res_pt_r;
      out_last_r  <= res_last_r;
      out_empty_r <= res_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      nz_r         <= '0;
      fetch_cell_r <= '0;
      fetch_slot_r <= '0;
      out_valid_r  <= 1'b0;
      cur_cell_r   <= '0;
      cur_pt_r     <= '0;
      n_r          <= '0;
      i_r          <= '0;
      pos_r        <= '0;
      sc_r         <= '0;
      ss_r         <= '0;
      phase_r      <= 1'b0;
      res_pt_r     <= '0;
      res_last_r   <= 1'b0;
      res_empty_r  <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            if (q_item.kind == KIND_ADD) begin
              cur_cell_r <= q_item.cell_idx[CW-1:0];
              cur_pt_r   <= q_item.pt;
              if (q_item.cell_idx < CELL_IDX_W'(MAX_CELLS)) begin
                state_r <= B_AHELD;
              end
            end else begin
              sc_r    <= SCW'(fetch_cell_r);
              ss_r    <= fetch_slot_r;
              phase_r <= 1'b0;
              state_r <= B_FRD;
            end
          end
        end
        B_AHELD: begin
          n_r     <= held;
          i_r     <= held;
          pos_r   <= '0;
          state_r <= (held == '0) ? B_AWR : B_ARD;
        end
        B_ARD: state_r <= B_ACMP;
        B_ACMP: begin
          // Walk up from the lowest kept point, moving weaker ones down a slot.
          if (st_rd.score >= cur_pt_r.score) begin
            pos_r   <= i_r;
            state_r <= B_AWR;
          end else begin
            i_r <= i_r - KW'(1);
            if (i_r == KW'(1)) begin
              pos_r   <= '0;
              state_r <= B_AWR;
            end else begin
              state_r <= B_ARD;
            end
          end
        end
        B_AWR: begin
          nz_r[cur_cell_r] <= (fill_new != '0);
          state_r          <= B_IDLE;
        end
        B_FRD: begin
          if (sc_r == SCW'(MAX_CELLS)) begin
            if (!phase_r) begin
              res_pt_r    <= '0;
              res_empty_r <= 1'b1;
              res_last_r  <= 1'b0;
            end else begin
              res_last_r  <= 1'b1;
            end
            nz_r         <= '0;
            fetch_cell_r <= '0;
            fetch_slot_r <= '0;
            state_r      <= B_EMIT;
          end else begin
            state_r <= B_FCHK;
          end
        end
        B_FCHK: begin
          if (ss_r < held) begin
            if (!phase_r) begin
              state_r <= B_FDAT;
            end else begin
              fetch_cell_r <= sc_r[CW-1:0];
              fetch_slot_r <= ss_r;
              state_r      <= B_EMIT;
            end
          end else begin
            sc_r    <= sc_r + SCW'(1);
            ss_r    <= '0;
            state_r <= B_FRD;
          end
        end
        B_FDAT: begin
          res_pt_r    <= st_rd;
          res_empty_r <= 1'b0;
          res_last_r  <= 1'b0;
          ss_r        <= ss_r + KW'(1);
          phase_r     <= 1'b1;
          state_r     <= B_FRD;
        end
        B_EMIT: begin
          if (emit_go) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/grid_bucket_top_n_select_core.sv =====
// ----------------------------------------------------------------------------
// grid_bucket_top_n_select_core
// Add: the front end runs a 13-step serial division, a clamp, a multiply and
// a push, and takes no new transaction until the push is taken; the back end
// then inserts into a cell by comparing against its kept points one by one.
// A fetch scans the fill table cell by cell, and its result is registered to
// the output. Synchronous active-low reset clears control state, fill valid
// bits and fetch position and loads 640, 480, 64, 4; the store is not swept.
// ----------------------------------------------------------------------------
module grid_bucket_top_n_select_core #(
  parameter int MAX_CELLS = 256,
  parameter int MAX_KEEP  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [gbsel_pkg::COORD_W-1:0]       in_point_x,
  input  logic [gbsel_pkg::COORD_W-1:0]       in_point_y,
  input  logic [gbsel_pkg::COORD_W-1:0]       in_score,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gbsel_pkg::COORD_W-1:0]       out_x,
  output logic [gbsel_pkg::COORD_W-1:0]       out_y,
  output logic [gbsel_pkg::COORD_W-1:0]       out_score,
  output logic                                out_is_last,
  output logic                                out_is_empty,
  input  logic                                cfg_we,
  input  logic [gbsel_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbsel_pkg::CFG_W-1:0]         cfg_data
);
  import gbsel_pkg::*;

  gbsel_cfg_t  cfg_r;
  logic        push_valid;
  logic        push_ready;
  gbsel_item_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  gbsel_item_t pop_item;

  // Configuration registers. Writes must come only while the block is idle, so
  // no transaction in flight sees a register change; the block does not check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= CFG_WIDTH_RST;
      cfg_r.image_height <= CFG_HEIGHT_RST;
      cfg_r.cell_size    <= CFG_SIZE_RST;
      cfg_r.keep_count   <= CFG_KEEP_RST;
    end else if (cfg_we) begin
      case (gbsel_cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        CFG_CELL_SIZE:    cfg_r.cell_size    <= cfg_data;
        CFG_KEEP_COUNT:   cfg_r.keep_count   <= cfg_data[KEEP_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: takes each input transaction and, for a point, works out the
  // grid cell index before handing it on.
  gbsel_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_score   (in_score),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // The queue lets the front end classify the next point while the back end
  // is still busy with an insertion or a fetch scan.
  gbsel_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back end: owns the point store and fill table, and drives the result
  // register, which holds a finished result while the consumer stalls.
  gbsel_back #(
    .MAX_CELLS (MAX_CELLS),
    .MAX_KEEP  (MAX_KEEP)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (pop_valid),
    .q_ready      (pop_ready),
    .q_item       (pop_item),
    .keep_count   (cfg_r.keep_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_score    (out_score),
    .out_is_last  (out_is_last),
    .out_is_empty (out_is_empty)
  );

endmodule
